// File: design/erbl_pkg.sv
// Shared types and constants of the error report backoff limiter.
package erbl_pkg;

  localparam int SLOTS   = 5;
  localparam int SLOT_AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CODE_W  = 16;
  localparam int TIME_W  = 32;
  localparam int CNT_W   = 32;
  localparam int CFG_IW  = 2;

  localparam logic [SLOT_AW-1:0] LAST_SLOT = SLOT_AW'(SLOTS - 1);

  localparam logic [TIME_W-1:0] CLEAR_INTERVAL_MS  = 32'd1000;
  localparam logic [TIME_W-1:0] RESET_INITIAL_MS   = 32'd1000;
  localparam logic [TIME_W-1:0] RESET_MAX_MS       = 32'd60000;
  localparam logic [TIME_W-1:0] RESET_THRESHOLD_MS = 32'd60000;
  localparam logic [CNT_W-1:0]  CNT_MAX            = '1;

  localparam logic [CFG_IW-1:0] CFG_INITIAL   = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_MAX       = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_THRESHOLD = 2'd2;

  localparam logic CMD_REPORT = 1'b0;
  localparam logic CMD_CLEAR  = 1'b1;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [TIME_W-1:0] last_time;
    logic [TIME_W-1:0] interval;
    logic [CNT_W-1:0]  count;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  typedef struct packed {
    logic [TIME_W-1:0] initial_ms;
    logic [TIME_W-1:0] max_ms;
    logic [TIME_W-1:0] threshold_ms;
  } cfg_t;

  typedef struct packed {
    logic              emitted;
    logic              repeated;
    logic [CNT_W-1:0]  occurrence;
    logic [TIME_W-1:0] interval_shown_ms;
    logic              persist;
    logic              untracked;
  } res_t;

endpackage

// File: design/error_report_backoff_limiter_top.sv
// Top level of the error report backoff limiter.
//
// Input channel (in_*): one beat carries a command (report or clear), an
// error code and the current millisecond time. A beat is taken at a rising
// edge with in_valid high and in_stall low. Output channel (out_*): one
// result beat per input beat, in order, held steady while out_stall is high.
// Configuration (cfg_*): write enable, register index and 32-bit data;
// index 0 initial interval, 1 maximum interval, 2 persistence threshold;
// other indexes are dropped. Write only while the block is idle.
// The slot table lives in one RAM with a registered read. An item scans
// the slots in order, one read per cycle with the check of the previous
// read overlapped; a report hit then passes a calculate state for the
// elapsed-time and doubling arithmetic, and every item a write-back state.
// One item is in work at a time; the next is taken once the engine is
// back in idle. A result waiting in the output register does not hold off
// the next item, which then waits in the engine with in_stall high.
// Synchronous reset frees all slots through per-slot valid bits and
// restores the register defaults.
module error_report_backoff_limiter_top (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_cmd,
  input  logic [erbl_pkg::CODE_W-1:0]      in_error_code,
  input  logic [erbl_pkg::TIME_W-1:0]      in_now_ms,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             out_emitted,
  output logic                             out_repeated,
  output logic [erbl_pkg::CNT_W-1:0]       out_occurrence,
  output logic [erbl_pkg::TIME_W-1:0]      out_interval_shown_ms,
  output logic                             out_persist,
  output logic                             out_untracked,
  input  logic                             cfg_we,
  input  logic [erbl_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [erbl_pkg::TIME_W-1:0]      cfg_wdata
);
  import erbl_pkg::*;

  cfg_t               cfg_r;
  logic               busy;
  logic               rd_en;
  logic [SLOT_AW-1:0] rd_addr;
  slot_t              rd_data;
  logic               wr_en;
  logic [SLOT_AW-1:0] wr_addr;
  slot_t              wr_data;
  logic               res_vld;
  res_t               res;
  logic               res_take;
  logic               out_valid_r;
  res_t               out_r;
  logic [SLOT_W-1:0]  rd_raw;

  // Configuration registers: take a write whenever the enable is high.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.initial_ms   <= RESET_INITIAL_MS;
      cfg_r.max_ms       <= RESET_MAX_MS;
      cfg_r.threshold_ms <= RESET_THRESHOLD_MS;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_INITIAL:   cfg_r.initial_ms   <= cfg_wdata;
        CFG_MAX:       cfg_r.max_ms       <= cfg_wdata;
        CFG_THRESHOLD: cfg_r.threshold_ms <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign in_stall = busy;

  erbl_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_raw)
  );

  assign rd_data = slot_t'(rd_raw);

  erbl_engine u_engine (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (in_valid && !in_stall),
    .cmd      (in_cmd),
    .code     (in_error_code),
    .now_ms   (in_now_ms),
    .cfg      (cfg_r),
    .busy     (busy),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take)
  );

  // Load the output register when it is empty or its beat leaves this cycle.
  assign res_take = res_vld && (!out_valid_r || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      out_r <= res;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_emitted           = out_r.emitted;
  assign out_repeated          = out_r.repeated;
  assign out_occurrence        = out_r.occurrence;
  assign out_interval_shown_ms = out_r.interval_shown_ms;
  assign out_persist           = out_r.persist;
  assign out_untracked         = out_r.untracked;

endmodule

// File: design/erbl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module erbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// File: design/erbl_engine.sv
// Slot scan and read-modify-write sequencer of the backoff limiter.
module erbl_engine (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           cmd,
  input  logic [erbl_pkg::CODE_W-1:0]    code,
  input  logic [erbl_pkg::TIME_W-1:0]    now_ms,
  input  erbl_pkg::cfg_t                 cfg,
  output logic                           busy,
  output logic                           rd_en,
  output logic [erbl_pkg::SLOT_AW-1:0]   rd_addr,
  input  erbl_pkg::slot_t                rd_data,
  output logic                           wr_en,
  output logic [erbl_pkg::SLOT_AW-1:0]   wr_addr,
  output erbl_pkg::slot_t                wr_data,
  output logic                           res_vld,
  output erbl_pkg::res_t                 res,
  input  logic                           res_take
);
  import erbl_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_CALC  = 5'b00100,
    ST_WRITE = 5'b01000,
    ST_DONE  = 5'b10000
  } state_t;

  state_t             state_r, state_nxt;
  logic [SLOT_AW-1:0] scan_idx_r, scan_idx_nxt;
  logic [SLOT_AW-1:0] chk_idx_r, chk_idx_nxt;
  logic               rd_vld_r, rd_vld_nxt;
  logic [SLOTS-1:0]   valid_r;

  logic               clr_r;
  logic [CODE_W-1:0]  code_r;
  logic [TIME_W-1:0]  now_r;
  logic               hit_r;
  slot_t              ent_r;
  logic [SLOT_AW-1:0] wr_addr_r;
  logic               emit_r;
  logic [TIME_W-1:0]  next_int_r;
  logic [CNT_W-1:0]   cnt_r;
  res_t               res_r;
  res_t               res_nxt;

  slot_t              slot_rd;
  logic               match;
  slot_t              claimed;
  logic [TIME_W-1:0]  elapsed;
  logic [TIME_W:0]    doubled;
  logic [TIME_W-1:0]  next_int;
  logic               persist;
  slot_t              updated;

  // Entries never written read as the all-zero reset slot.
  assign slot_rd = valid_r[chk_idx_r] ? rd_data : '0;
  assign match   = (slot_rd.code == code_r) ||
                   ((clr_r == CMD_REPORT) && (slot_rd.code == '0));

  always_comb begin
    claimed = slot_rd;
    if (slot_rd.code == '0) begin
      claimed.code      = code_r;
      claimed.last_time = '0;
      claimed.interval  = cfg.initial_ms;
      claimed.count     = '0;
    end
  end

  assign elapsed  = now_r - ent_r.last_time;
  assign doubled  = {ent_r.interval, 1'b0};
  assign next_int = (doubled < {1'b0, cfg.max_ms}) ? doubled[TIME_W-1:0] : cfg.max_ms;
  assign persist  = (cnt_r == CNT_W'(1)) || (next_int_r >= cfg.threshold_ms);

  always_comb begin
    updated           = ent_r;
    updated.last_time = now_r;
    updated.interval  = next_int_r;
    updated.count     = cnt_r;
  end

  always_comb begin
    state_nxt    = state_r;
    scan_idx_nxt = scan_idx_r;
    chk_idx_nxt  = chk_idx_r;
    rd_vld_nxt   = rd_vld_r;
    rd_en        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        scan_idx_nxt = '0;
        rd_vld_nxt   = 1'b0;
        if (start) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        // Issue the next read while checking the data of the previous one.
        rd_en       = 1'b1;
        rd_vld_nxt  = 1'b1;
        chk_idx_nxt = scan_idx_r;
        if (scan_idx_r != LAST_SLOT) begin
          scan_idx_nxt = scan_idx_r + 1'b1;
        end
        if (rd_vld_r && match) begin
          state_nxt = (clr_r == CMD_CLEAR) ? ST_WRITE : ST_CALC;
        end else if (rd_vld_r && (chk_idx_r == LAST_SLOT)) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_CALC:  state_nxt = ST_WRITE;
      ST_WRITE: state_nxt = ST_DONE;
      ST_DONE: begin
        if (res_take) begin
          state_nxt = ST_IDLE;
        end
      end
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      scan_idx_r <= '0;
      chk_idx_r  <= '0;
      rd_vld_r   <= 1'b0;
      valid_r    <= '0;
      hit_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      scan_idx_r <= scan_idx_nxt;
      chk_idx_r  <= chk_idx_nxt;
      rd_vld_r   <= rd_vld_nxt;
      if (wr_en) begin
        valid_r[wr_addr_r] <= 1'b1;
      end
      if (state_r == ST_IDLE) begin
        hit_r <= 1'b0;
      end else if ((state_r == ST_SCAN) && rd_vld_r && match) begin
        hit_r <= 1'b1;
      end
    end
  end

  // Result: zero for a clear, pass-through for a full table, a hit's verdict.
  always_comb begin
    res_nxt = '0;
    if (clr_r == CMD_REPORT) begin
      if (!hit_r) begin
        res_nxt.emitted   = 1'b1;
        res_nxt.persist   = 1'b1;
        res_nxt.untracked = 1'b1;
      end else if (emit_r) begin
        res_nxt.emitted           = 1'b1;
        res_nxt.repeated          = (cnt_r > CNT_W'(1));
        res_nxt.occurrence        = cnt_r;
        res_nxt.interval_shown_ms = ent_r.interval;
        res_nxt.persist           = persist;
      end else begin
        res_nxt.occurrence        = ent_r.count;
        res_nxt.interval_shown_ms = ent_r.interval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_IDLE) && start) begin
      clr_r  <= cmd;
      code_r <= code;
      now_r  <= now_ms;
    end
    if ((state_r == ST_SCAN) && rd_vld_r && match) begin
      ent_r     <= claimed;
      wr_addr_r <= chk_idx_r;
    end
    if (state_r == ST_CALC) begin
      emit_r     <= (elapsed >= ent_r.interval);
      next_int_r <= next_int;
      cnt_r      <= (ent_r.count == CNT_MAX) ? ent_r.count : ent_r.count + 1'b1;
    end
    if (state_r == ST_WRITE) begin
      res_r <= res_nxt;
    end
  end

  always_comb begin
    wr_en   = (state_r == ST_WRITE) && hit_r;
    wr_data = ent_r;
    if (clr_r == CMD_CLEAR) begin
      wr_data.code      = '0;
      wr_data.last_time = '0;
      wr_data.interval  = CLEAR_INTERVAL_MS;
      wr_data.count     = '0;
    end else if (emit_r) begin
      wr_data = updated;
    end
  end

  assign wr_addr = wr_addr_r;
  assign rd_addr = scan_idx_r;
  assign busy    = (state_r != ST_IDLE);
  assign res_vld = (state_r == ST_DONE);
  assign res     = res_r;

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for the error report backoff limiter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import erbl_pkg::*;

  // Register index past the end of the list: the block must drop the write.
  localparam logic [CFG_IW-1:0] CFG_UNUSED = 2'd3;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int HOLD_CYCLES   = 300;       // long receiver hold-off
  localparam int SETTLE_CYCLES = SLOTS + 6; // worst item latency plus margin
  localparam int SHOW_LIMIT    = 10;        // mismatches printed in full

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic                in_cmd;
  logic [CODE_W-1:0]   in_error_code;
  logic [TIME_W-1:0]   in_now_ms;
  logic                out_valid;
  logic                out_stall;
  logic                out_emitted;
  logic                out_repeated;
  logic [CNT_W-1:0]    out_occurrence;
  logic [TIME_W-1:0]   out_interval_shown_ms;
  logic                out_persist;
  logic                out_untracked;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [TIME_W-1:0]   cfg_wdata;

  error_report_backoff_limiter_top u_dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_cmd                (in_cmd),
    .in_error_code         (in_error_code),
    .in_now_ms             (in_now_ms),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_emitted           (out_emitted),
    .out_repeated          (out_repeated),
    .out_occurrence        (out_occurrence),
    .out_interval_shown_ms (out_interval_shown_ms),
    .out_persist           (out_persist),
    .out_untracked         (out_untracked),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata)
  );

  // 20 ns clock period.
  initial clk = 1'b0;
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Mirror of the limiter: slot table and register values as the block should
  // hold them after every accepted beat.
  // ---------------------------------------------------------------------------
  slot_t   slot_mirror [SLOTS];
  cfg_t    regs;
  res_t    expected_verdicts [$];

  bit      offering;     // in_valid is currently held high by the sender
  bit      idle_on;      // random gaps on both channels
  logic    pressure_on;  // ask the receiver for one long hold-off

  int      n_items;
  int      n_emitted;
  int      n_suppressed;
  int      n_untracked;
  int      n_clears;
  int      n_results;
  int      n_mismatch;
  int      cycle_count;

  // Work out the verdict for one beat and advance the slot mirror.
  function automatic res_t judge_report(logic cmd, logic [CODE_W-1:0] code,
                                        logic [TIME_W-1:0] now);
    res_t              r;
    int                hit;
    logic [TIME_W-1:0] elapsed;
    logic [TIME_W-1:0] shown;
    logic [TIME_W-1:0] next_iv;
    logic [TIME_W:0]   doubled;
    r   = '0;
    hit = -1;
    if (cmd == CMD_CLEAR) begin
      n_clears++;
      for (int i = 0; i < SLOTS; i++)
        if (hit < 0 && slot_mirror[i].code == code) hit = i;
      if (hit >= 0) begin
        slot_mirror[hit].code      = '0;
        slot_mirror[hit].last_time = '0;
        slot_mirror[hit].interval  = CLEAR_INTERVAL_MS;
        slot_mirror[hit].count     = '0;
      end
      return r;
    end
    // First slot in index order holding the code or free.
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && (slot_mirror[i].code == code || slot_mirror[i].code == '0)) hit = i;
    if (hit < 0) begin
      // Table full: let it through and persist, leave the table alone.
      r.emitted   = 1'b1;
      r.persist   = 1'b1;
      r.untracked = 1'b1;
      n_untracked++;
      return r;
    end
    if (slot_mirror[hit].code == '0) begin
      slot_mirror[hit].code      = code;
      slot_mirror[hit].interval  = regs.initial_ms;
      slot_mirror[hit].last_time = '0;
      slot_mirror[hit].count     = '0;
    end
    elapsed = now - slot_mirror[hit].last_time;
    if (elapsed >= slot_mirror[hit].interval) begin
      shown = slot_mirror[hit].interval;
      if (slot_mirror[hit].count != CNT_MAX) slot_mirror[hit].count++;
      slot_mirror[hit].last_time = now;
      // Double one bit wider so a large interval cannot wrap before the cap.
      doubled = {1'b0, shown} << 1;
      next_iv = (doubled < {1'b0, regs.max_ms}) ? doubled[TIME_W-1:0] : regs.max_ms;
      slot_mirror[hit].interval = next_iv;
      r.emitted           = 1'b1;
      r.repeated          = slot_mirror[hit].count > 1;
      r.occurrence        = slot_mirror[hit].count;
      r.interval_shown_ms = shown;
      r.persist           = (slot_mirror[hit].count == 1) || (next_iv >= regs.threshold_ms);
      n_emitted++;
    end else begin
      r.occurrence        = slot_mirror[hit].count;
      r.interval_shown_ms = slot_mirror[hit].interval;
      n_suppressed++;
    end
    return r;
  endfunction

  // Idle stretch: mostly short, now and then long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 93) return $urandom_range(4, 8);
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (!idle_on || $urandom_range(0, 99) < 55) return 0;
    return idle_len();
  endfunction

  // ---------------------------------------------------------------------------
  // Sender: offer one beat, hold it until taken, then record its verdict.
  // Valid stays high on return so a back-to-back beat never drops it.
  // ---------------------------------------------------------------------------
  task automatic send_item(logic cmd, logic [CODE_W-1:0] code, logic [TIME_W-1:0] now);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      if (offering) begin
        in_valid <= 1'b0;
        offering = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_error_code <= code;
    in_now_ms     <= now;
    offering = 1'b1;
    do @(posedge clk); while (in_stall);
    expected_verdicts.push_back(judge_report(cmd, code, now));
    n_items++;
  endtask

  // Drop valid, wait for every verdict, then let the block settle.
  task automatic drain();
    if (offering) begin
      in_valid <= 1'b0;
      offering = 1'b0;
    end
    while (expected_verdicts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, logic [TIME_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_INITIAL:   regs.initial_ms   = val;
      CFG_MAX:       regs.max_ms       = val;
      CFG_THRESHOLD: regs.threshold_ms = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_regs(logic [TIME_W-1:0] init_ms, logic [TIME_W-1:0] max_ms,
                          logic [TIME_W-1:0] thr_ms);
    write_reg(CFG_INITIAL, init_ms);
    write_reg(CFG_MAX, max_ms);
    write_reg(CFG_THRESHOLD, thr_ms);
  endtask

  // Clear every occupied slot; ascending order means each clear hits its own slot.
  task automatic flush_slots();
    for (int i = 0; i < SLOTS; i++)
      if (slot_mirror[i].code != '0) send_item(CMD_CLEAR, slot_mirror[i].code, '0);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Default registers: claim, suppress, emit, double, wrapped elapsed time.
  task automatic test_defaults_after_reset();
    send_item(CMD_REPORT, 16'h0001, 32'd0);          // claimed, held back
    send_item(CMD_REPORT, 16'h0001, 32'd1000);       // first emission, persists
    send_item(CMD_REPORT, 16'h0001, 32'd2999);       // one short of the doubled interval
    send_item(CMD_REPORT, 16'h0001, 32'd3000);       // repeated
    send_item(CMD_REPORT, 16'hFFFF, 32'hFFFF_FFFF);  // extreme code and time
    send_item(CMD_REPORT, 16'hFFFF, 32'h0000_0100);  // elapsed wraps round zero
    send_item(CMD_CLEAR,  16'h0001, 32'd0);
  endtask

  // Fill the table, overflow it, clear, duplicate codes and code zero.
  task automatic test_table_exhaustion();
    send_item(CMD_REPORT, 16'h0002, 32'd5000);
    send_item(CMD_REPORT, 16'h0004, 32'd5000);
    send_item(CMD_REPORT, 16'h0008, 32'd5000);
    send_item(CMD_REPORT, 16'h0010, 32'd5000);
    send_item(CMD_REPORT, 16'h8000, 32'd5001);  // no slot left
    send_item(CMD_CLEAR,  16'h1234, 32'd5002);  // clear with no match
    send_item(CMD_CLEAR,  16'h0004, 32'd5003);
    // Freed slot sits ahead of the one still holding this code.
    send_item(CMD_REPORT, 16'h0008, 32'd9000);
    send_item(CMD_CLEAR,  16'h0002, 32'd9001);
    send_item(CMD_REPORT, 16'h0000, 32'd7000);  // code zero borrows a free slot
    send_item(CMD_CLEAR,  16'h0000, 32'd7001);  // and clear of code zero hits it
  endtask

  // Register extremes: wide doubling, caps of one, thresholds at both ends.
  task automatic test_interval_extremes();
    drain();
    set_regs(32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);        // must be ignored
    flush_slots();
    send_item(CMD_REPORT, 16'h0042, 32'hFFFF_FFFF);  // doubling overflows 32 bits
    send_item(CMD_REPORT, 16'h0042, 32'h7FFF_FFFF);
    drain();
    set_regs(32'hFFFF_FFFF, 32'd1, 32'd0);
    send_item(CMD_REPORT, 16'h0043, 32'hFFFF_FFFF);
    send_item(CMD_REPORT, 16'h0043, 32'd0);          // one tick after wrap, repeated
    send_item(CMD_REPORT, 16'h0043, 32'd0);          // same instant, held back
  endtask

  // One random phase: a small pool of codes recurring over advancing time,
  // with clears, stray codes and time jumps mixed in.
  task automatic run_random_phase(int count, logic [TIME_W-1:0] init_ms,
                                  logic [TIME_W-1:0] max_ms, logic [TIME_W-1:0] thr_ms,
                                  int step_max, bit gaps);
    logic [CODE_W-1:0] pool [7];
    logic [TIME_W-1:0] stamp;
    int                r;
    drain();
    set_regs(init_ms, max_ms, thr_ms);
    idle_on = gaps;
    foreach (pool[i]) pool[i] = CODE_W'($urandom_range(1, 16'hFFFF));
    if ($urandom_range(0, 3) == 0) pool[6] = '0;
    stamp = $urandom;
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < 3) stamp = $urandom;
      else stamp = stamp + $urandom_range(0, step_max);
      if (r < 75)
        send_item(CMD_REPORT, pool[$urandom_range(0, 6)], stamp);
      else if (r < 87)
        send_item(CMD_CLEAR, pool[$urandom_range(0, 6)], stamp);
      else if (r < 95)
        send_item(CMD_REPORT, CODE_W'($urandom_range(0, 16'hFFFF)), $urandom);
      else
        send_item(CMD_CLEAR, CODE_W'($urandom_range(0, 16'hFFFF)), stamp);
    end
  endtask

  task automatic test_random_traffic();
    run_random_phase(280, 32'd1000, 32'd60000, 32'd60000, 8000, 1'b1);
    run_random_phase(280, 32'd1, 32'd64, 32'd16, 40, 1'b0);   // no idling here
    run_random_phase(280, 32'd50, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 200, 1'b1);
    run_random_phase(280, 32'd1, 32'd1, 32'd0, 2, 1'b1);
  endtask

  // Receiver holds off long enough for the block to fill and stall its input.
  task automatic test_output_backpressure();
    drain();
    idle_on = 1'b0;
    pressure_on <= 1'b1;
    for (int i = 0; i < 40; i++)
      send_item(i[0] ? CMD_REPORT : CMD_CLEAR, 16'h0100 + i[2:0], 32'd2000 * i);
    drain();
    pressure_on <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random stall bursts, plus one long counted hold-off on request.
  // ---------------------------------------------------------------------------
  initial begin : receiver
    int  burst;
    int  hold_left;
    bit  hold_seen;
    burst     = 0;
    hold_left = 0;
    hold_seen = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (pressure_on === 1'b1 && !hold_seen) begin
        hold_seen = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (idle_on && $urandom_range(0, 99) < 15) begin
        burst = idle_len() - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Checker: compare every result beat with the oldest verdict waiting.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    res_t got;
    res_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.emitted           = out_emitted;
      got.repeated          = out_repeated;
      got.occurrence        = out_occurrence;
      got.interval_shown_ms = out_interval_shown_ms;
      got.persist           = out_persist;
      got.untracked         = out_untracked;
      if (expected_verdicts.size() == 0) begin
        n_mismatch++;
        if (n_mismatch <= SHOW_LIMIT)
          $display("[%0t] result beat %0d arrived with no verdict waiting", $realtime,
                   n_results);
      end else begin
        want = expected_verdicts.pop_front();
        if (got.emitted !== want.emitted || got.repeated !== want.repeated ||
            got.occurrence !== want.occurrence ||
            got.interval_shown_ms !== want.interval_shown_ms ||
            got.persist !== want.persist || got.untracked !== want.untracked) begin
          n_mismatch++;
          if (n_mismatch <= SHOW_LIMIT) begin
            $display("[%0t] beat %0d exp: em=%0b rep=%0b occ=%0d iv=%0d per=%0b unt=%0b",
                     $realtime, n_results, want.emitted, want.repeated, want.occurrence,
                     want.interval_shown_ms, want.persist, want.untracked);
            $display("%s got: em=%0b rep=%0b occ=%0d iv=%0d per=%0b unt=%0b", "        ",
                     got.emitted, got.repeated, got.occurrence, got.interval_shown_ms,
                     got.persist, got.untracked);
          end
        end
      end
      n_results++;
    end
  end

  // Watchdog: end the run if it goes far past any sane length.
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("watchdog expired after %0d cycles", cycle_count);
    $display("TEST FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    in_valid      <= 1'b0;
    in_cmd        <= CMD_REPORT;
    in_error_code <= '0;
    in_now_ms     <= '0;
    cfg_we        <= 1'b0;
    cfg_index     <= CFG_INITIAL;
    cfg_wdata     <= '0;
    pressure_on   <= 1'b0;
    rst_n         <= 1'b0;
    offering     = 1'b0;
    idle_on      = 1'b0;
    n_items      = 0;
    n_emitted    = 0;
    n_suppressed = 0;
    n_untracked  = 0;
    n_clears     = 0;
    n_results    = 0;
    n_mismatch   = 0;
    // Reset state of the mirror: all slots free, register defaults.
    foreach (slot_mirror[i]) slot_mirror[i] = '0;
    regs.initial_ms   = RESET_INITIAL_MS;
    regs.max_ms       = RESET_MAX_MS;
    regs.threshold_ms = RESET_THRESHOLD_MS;

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_defaults_after_reset();
    idle_on = 1'b1;
    test_table_exhaustion();
    test_interval_extremes();
    test_random_traffic();
    test_output_backpressure();
    drain();

    $display("Run covered %0d beats: %0d emitted, %0d held back, %0d with no free slot,",
             n_items, n_emitted, n_suppressed, n_untracked);
    $display("%0d clears, %0d results checked, %0d mismatches, %0d cycles.",
             n_clears, n_results, n_mismatch, cycle_count);
    if (n_mismatch == 0 && expected_verdicts.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
